[src/bsfr_pkg.sv]
`default_nettype none

package bsfr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTORE_MASK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PACKET_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LIMIT = 3'd4;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RESET = 8'd255;
   localparam logic [BYTE_W-1:0] RESTORE_MASK_RESET = 8'd128;
   localparam logic [BYTE_W-1:0] PACKET_LENGTH_RESET = 8'd16;
   localparam logic [BYTE_W-1:0] BUFFER_LIMIT_RESET = 8'd255;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      byte_type start_byte;
      byte_type escape_byte;
      byte_type restore_mask;
      byte_type packet_length;
      byte_type buffer_limit;
   } cfg_type;

   typedef struct packed {
      byte_type decoded_byte;
      byte_type byte_position;
      logic     packet_complete;
      logic     overflow_abort;
   } rsp_type;

endpackage

`default_nettype wire

[src/bsfr_if.sv]
`default_nettype none

interface bsfr_req_if;
   logic               valid;
   logic               ready;
   bsfr_pkg::byte_type line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink (input valid, input line_byte, output ready);
endinterface

interface bsfr_rsp_if;
   logic               valid;
   logic               ready;
   bsfr_pkg::byte_type decoded_byte;
   bsfr_pkg::byte_type byte_position;
   logic               packet_complete;
   logic               overflow_abort;

   modport source (
      output valid, output decoded_byte, output byte_position,
      output packet_complete, output overflow_abort, input ready
   );
   modport sink (
      input valid, input decoded_byte, input byte_position,
      input packet_complete, input overflow_abort, output ready
   );
endinterface

`default_nettype wire

[src/bsfr_csr.sv]
`default_nettype none

module bsfr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [bsfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bsfr_pkg::BYTE_W-1:0]         csr_wdata,
   output bsfr_pkg::cfg_type                        cfg
);

   bsfr_pkg::cfg_type cfg_ff;
   bsfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bsfr_pkg::CSR_START_BYTE:    cfg_in.start_byte = csr_wdata;
            bsfr_pkg::CSR_ESCAPE_BYTE:   cfg_in.escape_byte = csr_wdata;
            bsfr_pkg::CSR_RESTORE_MASK:  cfg_in.restore_mask = csr_wdata;
            bsfr_pkg::CSR_PACKET_LENGTH: cfg_in.packet_length = csr_wdata;
            bsfr_pkg::CSR_BUFFER_LIMIT:  cfg_in.buffer_limit = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= bsfr_pkg::START_BYTE_RESET;
         cfg_ff.escape_byte   <= bsfr_pkg::ESCAPE_BYTE_RESET;
         cfg_ff.restore_mask  <= bsfr_pkg::RESTORE_MASK_RESET;
         cfg_ff.packet_length <= bsfr_pkg::PACKET_LENGTH_RESET;
         cfg_ff.buffer_limit  <= bsfr_pkg::BUFFER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/bsfr_decode.sv]
`default_nettype none

module bsfr_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsfr_pkg::cfg_type cfg,
   bsfr_req_if.sink               req,
   input  wire logic              out_free,
   output logic                   load,
   output bsfr_pkg::rsp_type      result
);

   logic               in_valid_ff;
   logic               in_valid_in;
   bsfr_pkg::byte_type in_byte_ff;

   logic               armed_ff;
   logic               armed_in;
   logic               escape_pending_ff;
   logic               escape_pending_in;
   bsfr_pkg::byte_type fill_count_ff;
   bsfr_pkg::byte_type fill_count_in;

   logic               has_result;
   logic               advance;
   bsfr_pkg::byte_type count_next;
   logic               done;
   logic               abort;

   assign count_next = fill_count_ff + 8'd1;
   assign done = (count_next == cfg.packet_length);
   assign abort = !done && (count_next == cfg.buffer_limit);

   always_comb begin
      has_result        = 1'b0;
      armed_in          = armed_ff;
      escape_pending_in = escape_pending_ff;
      fill_count_in     = fill_count_ff;
      priority if (in_byte_ff == cfg.start_byte) begin
         armed_in          = 1'b1;
         escape_pending_in = 1'b0;
         fill_count_in     = '0;
      end else if (!armed_ff) begin
         armed_in = 1'b0;
      end else if (in_byte_ff == cfg.escape_byte) begin
         escape_pending_in = 1'b1;
      end else begin
         has_result        = 1'b1;
         escape_pending_in = 1'b0;
         if (done || abort) begin
            armed_in      = 1'b0;
            fill_count_in = '0;
         end else begin
            fill_count_in = count_next;
         end
      end
   end

   assign result.decoded_byte    = escape_pending_ff ? (in_byte_ff | cfg.restore_mask)
                                                     : in_byte_ff;
   assign result.byte_position   = fill_count_ff;
   assign result.packet_complete = done;
   assign result.overflow_abort  = abort;

   // drop items without a result, hold the stage only when a result cannot move
   assign advance     = in_valid_ff && (!has_result || out_free);
   assign load        = advance && has_result;
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.valid || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         armed_ff          <= 1'b0;
         escape_pending_ff <= 1'b0;
         fill_count_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            armed_ff          <= armed_in;
            escape_pending_ff <= escape_pending_in;
            fill_count_ff     <= fill_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.line_byte;
      end
   end

endmodule

`default_nettype wire

[src/bsfr_out_reg.sv]
`default_nettype none

module bsfr_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bsfr_pkg::rsp_type result,
   output logic                   out_free,
   bsfr_rsp_if.source             rsp
);

   logic              valid_ff;
   logic              valid_in;
   bsfr_pkg::rsp_type data_ff;

   assign out_free = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.decoded_byte    = data_ff.decoded_byte;
   assign rsp.byte_position   = data_ff.byte_position;
   assign rsp.packet_complete = data_ff.packet_complete;
   assign rsp.overflow_abort  = data_ff.overflow_abort;

endmodule

`default_nettype wire

[src/byte_stuffed_frame_receiver.sv]
// Byte-stuffed frame receiver with fixed packet length.
// req_ch carries one raw line byte per item (valid/ready). rsp_ch carries one
// decoded byte per item with its position in the packet and the complete and
// abort flags. Start, escape and ignored bytes give no result item.
// The csr_ port writes one of five 8-bit registers per cycle: start byte,
// escape byte, restore mask, packet length, buffer limit. The user must write
// only while idle; the block itself does not enforce it. An accepted byte is
// registered in the input register, decoded and loaded into the result
// register once that register is free, then offered on rsp_ch. Throughput is
// one item per cycle while rsp_ch does not stall; the armed flag, the escape
// flag and the fill counter update as each byte leaves the input register.
// Reset clears both pipeline registers and the frame state (not armed) and
// loads the register defaults; no result is pending after reset.
// When rsp_ch.ready is low, a finished result waits in the result register
// while the input register still takes one more byte; bytes that give no
// result keep flowing. A result held in the input register stalls req_ch.
`default_nettype none

module byte_stuffed_frame_receiver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bsfr_req_if.sink                              req_ch,
   bsfr_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [bsfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bsfr_pkg::BYTE_W-1:0]      csr_wdata
);

   bsfr_pkg::cfg_type cfg;
   bsfr_pkg::rsp_type result;
   logic              load;
   logic              out_free;

   bsfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bsfr_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_ch),
      .out_free (out_free),
      .load     (load),
      .result   (result)
   );

   bsfr_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .out_free (out_free),
      .rsp      (rsp_ch)
   );

   a_flags_exclusive: assert property (
      @(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.packet_complete && rsp_ch.overflow_abort)
   ) else $error("complete and abort flagged on the same item");

   a_complete_at_length: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.packet_complete) |->
         (8'(rsp_ch.byte_position + 8'd1) == cfg.packet_length)
   ) else $error("packet complete at wrong position");

   a_abort_at_limit: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.overflow_abort) |->
         (8'(rsp_ch.byte_position + 8'd1) == cfg.buffer_limit)
   ) else $error("abort at wrong position");

   a_no_result_after_reset: assert property (
      @(posedge clock)
      $past(reset) |-> !rsp_ch.valid
   ) else $error("result valid right after reset");

endmodule

`default_nettype wire

[verif/byte_stuffed_frame_receiver_test.sv]
module byte_stuffed_frame_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bsfr_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [bsfr_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int LONG_HOLD = 200;
   localparam int SETTLE_CYCLES = 6;

   localparam bsfr_pkg::byte_type DIRECTED_A [13] = '{
      8'h55, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h02, 8'hFF, 8'hFF, 8'h03, 8'hFF, 8'h00,
      8'h7F, 8'hFE
   };
   localparam bsfr_pkg::byte_type DIRECTED_B [8] = '{
      8'hFF, 8'h00, 8'h7E, 8'h01, 8'hFF, 8'hFF, 8'h80, 8'h81
   };
   localparam bsfr_pkg::byte_type DIRECTED_C [6] = '{
      8'h7E, 8'h7D, 8'h5E, 8'h01, 8'h02, 8'h03
   };

   class frame_scoreboard;
      bsfr_pkg::cfg_type  cfg;
      bit                 armed;
      bit                 escape_pending;
      bsfr_pkg::byte_type fill_count;
      bsfr_pkg::rsp_type  decoded_q[$];
      int                 errors;

      function new();
         cfg.start_byte    = bsfr_pkg::START_BYTE_RESET;
         cfg.escape_byte   = bsfr_pkg::ESCAPE_BYTE_RESET;
         cfg.restore_mask  = bsfr_pkg::RESTORE_MASK_RESET;
         cfg.packet_length = bsfr_pkg::PACKET_LENGTH_RESET;
         cfg.buffer_limit  = bsfr_pkg::BUFFER_LIMIT_RESET;
         armed          = 1'b0;
         escape_pending = 1'b0;
         fill_count     = '0;
         errors         = 0;
      endfunction

      function void write_reg(logic [bsfr_pkg::CSR_INDEX_W-1:0] index,
                              bsfr_pkg::byte_type value);
         case (index)
            bsfr_pkg::CSR_START_BYTE:    cfg.start_byte    = value;
            bsfr_pkg::CSR_ESCAPE_BYTE:   cfg.escape_byte   = value;
            bsfr_pkg::CSR_RESTORE_MASK:  cfg.restore_mask  = value;
            bsfr_pkg::CSR_PACKET_LENGTH: cfg.packet_length = value;
            bsfr_pkg::CSR_BUFFER_LIMIT:  cfg.buffer_limit  = value;
            default: ;
         endcase
      endfunction

      function void note_input(bsfr_pkg::byte_type line_byte);
         bsfr_pkg::rsp_type  item;
         bsfr_pkg::byte_type value;
         value = line_byte;
         if (value == cfg.start_byte) begin
            armed          = 1'b1;
            escape_pending = 1'b0;
            fill_count     = '0;
            return;
         end
         if (!armed) return;
         if (value == cfg.escape_byte) begin
            escape_pending = 1'b1;
            return;
         end
         if (escape_pending) value = value | cfg.restore_mask;
         item.decoded_byte    = value;
         item.byte_position   = fill_count;
         item.packet_complete = 1'b0;
         item.overflow_abort  = 1'b0;
         fill_count     = fill_count + 8'd1;
         escape_pending = 1'b0;
         if (fill_count == cfg.packet_length) begin
            item.packet_complete = 1'b1;
            armed      = 1'b0;
            fill_count = '0;
         end else if (fill_count == cfg.buffer_limit) begin
            item.overflow_abort = 1'b1;
            armed      = 1'b0;
            fill_count = '0;
         end
         decoded_q.push_back(item);
      endfunction

      function void check_result(bsfr_pkg::rsp_type got);
         bsfr_pkg::rsp_type want;
         if (decoded_q.size() == 0) begin
            $display("%0t unexpected item: decoded_byte %0h byte_position %0d",
                     $time, got.decoded_byte, got.byte_position);
            errors++;
            return;
         end
         want = decoded_q.pop_front();
         if (got.decoded_byte !== want.decoded_byte) begin
            $display("%0t decoded_byte mismatch: expected %0h, actual %0h",
                     $time, want.decoded_byte, got.decoded_byte);
            errors++;
         end
         if (got.byte_position !== want.byte_position) begin
            $display("%0t byte_position mismatch: expected %0d, actual %0d",
                     $time, want.byte_position, got.byte_position);
            errors++;
         end
         if (got.packet_complete !== want.packet_complete) begin
            $display("%0t packet_complete mismatch: expected %0b, actual %0b",
                     $time, want.packet_complete, got.packet_complete);
            errors++;
         end
         if (got.overflow_abort !== want.overflow_abort) begin
            $display("%0t overflow_abort mismatch: expected %0b, actual %0b",
                     $time, want.overflow_abort, got.overflow_abort);
            errors++;
         end
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [bsfr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bsfr_pkg::BYTE_W-1:0]      csr_wdata;

   bit idle_on;
   bit hold_req;
   int sent_items;

   frame_scoreboard sb;

   bsfr_req_if req_bus ();
   bsfr_rsp_if rsp_bus ();

   byte_stuffed_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int burst;
      int hold;
      burst = 0;
      hold  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold     = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_bus.ready = 1'b0;
            hold--;
         end else if (burst > 0) begin
            rsp_bus.ready = 1'b0;
            burst--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            burst = $urandom_range(1, 3) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      bsfr_pkg::rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.decoded_byte    = rsp_bus.decoded_byte;
         got.byte_position   = rsp_bus.byte_position;
         got.packet_complete = rsp_bus.packet_complete;
         got.overflow_abort  = rsp_bus.overflow_abort;
         sb.check_result(got);
      end
   end

   task automatic send_byte(input bsfr_pkg::byte_type line_byte);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.line_byte = line_byte;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(line_byte);
      sent_items++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bsfr_pkg::CSR_INDEX_W-1:0] index,
                            input bsfr_pkg::byte_type value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      sb.write_reg(index, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_config(input bsfr_pkg::byte_type start_b,
                              input bsfr_pkg::byte_type escape_b,
                              input bsfr_pkg::byte_type mask,
                              input bsfr_pkg::byte_type length,
                              input bsfr_pkg::byte_type limit);
      settle();
      write_reg(bsfr_pkg::CSR_START_BYTE, start_b);
      write_reg(bsfr_pkg::CSR_ESCAPE_BYTE, escape_b);
      write_reg(bsfr_pkg::CSR_RESTORE_MASK, mask);
      write_reg(bsfr_pkg::CSR_PACKET_LENGTH, length);
      write_reg(bsfr_pkg::CSR_BUFFER_LIMIT, limit);
      write_reg($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                bsfr_pkg::byte_type'($urandom_range(0, 255)));
   endtask

   task automatic send_payload_byte();
      bsfr_pkg::byte_type data;
      if ($urandom_range(0, 4) == 0) send_byte(sb.cfg.escape_byte);
      do data = bsfr_pkg::byte_type'($urandom_range(0, 255));
      while (data == sb.cfg.start_byte || data == sb.cfg.escape_byte);
      send_byte(data);
   endtask

   task automatic run_frames(input int n_items);
      int first;
      int kind;
      int len_eff;
      int limit_eff;
      int target;
      int extra;
      first = sent_items;
      while (sent_items - first < n_items) begin
         len_eff   = (sb.cfg.packet_length == 0) ? 256 : sb.cfg.packet_length;
         limit_eff = (sb.cfg.buffer_limit == 0) ? 256 : sb.cfg.buffer_limit;
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            extra = $urandom_range(1, 3);
            repeat (extra) send_byte(bsfr_pkg::byte_type'($urandom_range(0, 255)));
         end else if (kind == 1) begin
            send_byte(sb.cfg.start_byte);
            target = $urandom_range(0, (len_eff < 6) ? len_eff - 1 : 5);
            repeat (target) send_payload_byte();
            if ($urandom_range(0, 1)) send_byte(sb.cfg.escape_byte);
         end else begin
            send_byte(sb.cfg.start_byte);
            target = len_eff;
            if (limit_eff < target) target = limit_eff + $urandom_range(0, 2);
            repeat (target) send_payload_byte();
            extra = $urandom_range(0, 2);
            repeat (extra) send_byte(bsfr_pkg::byte_type'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      int i;
      sb = new();
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.line_byte = '0;
      idle_on           = 1'b1;
      hold_req          = 1'b0;
      sent_items        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_A[k]) send_byte(DIRECTED_A[k]);
      load_config(8'hFF, 8'hFF, 8'hFF, 8'd2, 8'd2);
      foreach (DIRECTED_B[k]) send_byte(DIRECTED_B[k]);
      load_config(8'h7E, 8'h7D, 8'h20, 8'd5, 8'd3);
      foreach (DIRECTED_C[k]) send_byte(DIRECTED_C[k]);

      load_config(8'h7E, 8'h7D, 8'h20, 8'd8, 8'd255);
      hold_req = 1'b1;
      run_frames(120);

      for (i = 0; i < 4; i++) begin
         load_config(bsfr_pkg::byte_type'($urandom_range(0, 255)),
                     bsfr_pkg::byte_type'($urandom_range(0, 255)),
                     bsfr_pkg::byte_type'($urandom_range(0, 255)),
                     bsfr_pkg::byte_type'($urandom_range(1, 12)),
                     bsfr_pkg::byte_type'($urandom_range(1, 12)));
         idle_on = (i % 2 == 0);
         run_frames(80);
      end

      idle_on = 1'b1;
      load_config(8'h00, 8'h01, 8'h00, 8'd1, 8'd1);
      run_frames(80);
      load_config(8'hAA, 8'h55, 8'hFF, 8'd255, 8'd255);
      run_frames(200);
      load_config(8'hC0, 8'hDB, 8'h80, 8'd0, 8'd0);
      run_frames(200);
      load_config(8'h12, 8'h34, 8'h56, 8'd0, 8'd40);
      run_frames(80);

      load_config(8'h3C, 8'h3D, 8'h01, 8'd6, 8'd40);
      idle_on = 1'b0;
      run_frames(80);

      settle();
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
src/bsfr_pkg.sv
src/bsfr_if.sv
src/bsfr_csr.sv
src/bsfr_decode.sv
src/bsfr_out_reg.sv
src/byte_stuffed_frame_receiver.sv
verif/byte_stuffed_frame_receiver_test.sv
